// ----- src/osd_pkg.sv -----
package osd_pkg;

  localparam int MAP_COLUMNS     = 50;
  localparam int MAP_ROWS        = 18;
  localparam int GLYPHS_PER_PAGE = 256;
  localparam int GLYPH_PIXELS    = 4096;
  localparam int FRAME_WIDTH     = 1440;
  localparam int FRAME_HEIGHT    = 810;

  localparam int CELL_DEPTH = MAP_COLUMNS * MAP_ROWS;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);
  localparam int FONT_DEPTH = 2 * GLYPHS_PER_PAGE * GLYPH_PIXELS;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);

  localparam int DIV_W = 11;
  localparam int DEN_W = 7;

  typedef enum logic [1:0] {
    KIND_CELL  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_FONT  = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_CHAR_COLUMNS = 3'd0,
    REG_CHAR_ROWS    = 3'd1,
    REG_GLYPH_WIDTH  = 3'd2,
    REG_GLYPH_HEIGHT = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5,
    REG_SECOND_PAGE  = 3'd6
  } reg_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num_x;
    logic [DEN_W-1:0] den_x;
    logic [DIV_W-1:0] num_y;
    logic [DEN_W-1:0] den_y;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo_x;
    logic [DEN_W-1:0] rem_x;
    logic [DIV_W-1:0] quo_y;
    logic [DEN_W-1:0] rem_y;
  } div_rsp_t;

endpackage

// ----- src/osd_ram.sv -----
module osd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/osd_div.sv -----
module osd_div import osd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [DEN_W-1:0] rx_q, rx_d, ry_q, ry_d, dx_q, dx_d, dy_q, dy_d;
  logic [DEN_W:0]   tx, ty;
  logic             gx, gy;

  always_comb begin
    tx = {rx_q, qx_q[DIV_W-1]};
    ty = {ry_q, qy_q[DIV_W-1]};
    gx = tx >= {1'b0, dx_q};
    gy = ty >= {1'b0, dy_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    qx_d = qx_q;
    qy_d = qy_q;
    rx_d = rx_q;
    ry_d = ry_q;
    dx_d = dx_q;
    dy_d = dy_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      qx_d = req_i.num_x;
      qy_d = req_i.num_y;
      rx_d = '0;
      ry_d = '0;
      dx_d = req_i.den_x;
      dy_d = req_i.den_y;
    end else if (busy_q) begin
      qx_d = {qx_q[DIV_W-2:0], gx};
      qy_d = {qy_q[DIV_W-2:0], gy};
      rx_d = gx ? DEN_W'(tx - {1'b0, dx_q}) : DEN_W'(tx);
      ry_d = gy ? DEN_W'(ty - {1'b0, dy_q}) : DEN_W'(ty);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d;
    qy_q <= qy_d;
    rx_q <= rx_d;
    ry_q <= ry_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  assign rsp_o = '{done: done_q, quo_x: qx_q, rem_x: rx_q, quo_y: qy_q, rem_y: ry_q};

endmodule

// ----- src/osd_character_overlay_renderer_core.sv -----
// Character-cell on-screen-display generator.
// Input stream (s_axis): tuser carries the item kind (cell write, map clear,
// font write, pixel query); tdata carries the remaining fields. Only a pixel
// query produces a transaction on the output stream (m_axis), four frame bytes.
// Configuration: cfg_valid_i/cfg_ready_o with a register index and data; it is
// always ready and must only be written while the block is idle.
// One item is handled at a time. Cell and font writes are completed as they are
// accepted. A pixel query outside the frame, left of or above the grid origin,
// or with a zero glyph size goes straight to the result step. Any other query
// runs the 11-step shared divider that finds the cell and glyph offset; it then
// ends when the cell lies outside the grid, reads the cell map and ends when the
// cell is empty, or else reads the cell map and then the font memory.
// A map clear is accepted, then sweeps the cell map one entry per cycle.
// After reset the same sweep runs before the first input item is accepted;
// registers return to their defaults.
// The result sits in an output register; when the receiver stalls, the next
// item is still accepted, and a later query holds in its last step until the
// output register is free.
module osd_character_overlay_renderer_core import osd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] cell_column, [10:6] cell_row, [19:11] char_code, [40:20] font_address,
  // [72:41] font_word, [83:73] pixel_x, [93:84] pixel_y, [95:94] zero
  input  logic [95:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] pixel_byte0, [15:8] pixel_byte1, [23:16] pixel_byte2, [31:24] pixel_byte3
  output logic [31:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_CODE, ST_FONT, ST_RES
  } state_e;

  state_e state_q, state_d;

  logic [5:0]  cols_q;
  logic [4:0]  rows_q;
  logic [6:0]  gw_q, gh_q;
  logic [10:0] ox_q;
  logic [9:0]  oy_q;
  logic        page2_q;

  logic [CELL_AW-1:0] clr_q, clr_d;
  logic [31:0]        res_q, res_d, out_q, out_d;
  logic               oval_q, oval_d;
  logic [13:0]        off_q, off_d;

  logic [5:0]  in_col;
  logic [4:0]  in_row;
  logic [8:0]  in_code;
  logic [20:0] in_faddr;
  logic [31:0] in_fword;
  logic [10:0] in_px;
  logic [9:0]  in_py;
  kind_e       in_kind;
  logic        s_acc, early;
  logic [5:0]  used_cols;
  logic [4:0]  used_rows;

  logic [CELL_AW-1:0] c_addr;
  logic               c_we, c_re;
  logic [8:0]         c_wdata, c_rdata;
  logic [FONT_AW-1:0] f_addr;
  logic               f_we, f_re;
  logic [31:0]        f_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_col   = s_axis_tdata_i[5:0];
  assign in_row   = s_axis_tdata_i[10:6];
  assign in_code  = s_axis_tdata_i[19:11];
  assign in_faddr = s_axis_tdata_i[40:20];
  assign in_fword = s_axis_tdata_i[72:41];
  assign in_px    = s_axis_tdata_i[83:73];
  assign in_py    = s_axis_tdata_i[93:84];
  assign in_kind  = kind_e'(s_axis_tuser_i);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = oval_q;
  assign m_axis_tdata_o  = out_q;

  assign used_cols = (32'(cols_q) < MAP_COLUMNS) ? cols_q : 6'(MAP_COLUMNS);
  assign used_rows = (32'(rows_q) < MAP_ROWS) ? rows_q : 5'(MAP_ROWS);

  assign early = (32'(in_px) >= FRAME_WIDTH) || (32'(in_py) >= FRAME_HEIGHT) ||
                 (gw_q == '0) || (gh_q == '0) || (in_px < ox_q) || (in_py < oy_q);

  always_comb begin
    div_req.start = s_acc && (in_kind == KIND_QUERY) && !early;
    div_req.num_x = in_px - ox_q;
    div_req.den_x = gw_q;
    div_req.num_y = DIV_W'(in_py - oy_q);
    div_req.den_y = gh_q;
  end

  osd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  osd_ram #(.DEPTH(CELL_DEPTH), .WIDTH(9)) u_cell_ram (
    .clk_i   (clk_i),
    .addr_i  (c_addr),
    .we_i    (c_we),
    .re_i    (c_re),
    .wdata_i (c_wdata),
    .rdata_o (c_rdata)
  );

  osd_ram #(.DEPTH(FONT_DEPTH), .WIDTH(32)) u_font_ram (
    .clk_i   (clk_i),
    .addr_i  (f_addr),
    .we_i    (f_we),
    .re_i    (f_re),
    .wdata_i (in_fword),
    .rdata_o (f_rdata)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    res_d   = res_q;
    off_d   = off_q;
    out_d   = out_q;
    oval_d  = oval_q;
    c_addr  = clr_q;
    c_we    = 1'b0;
    c_re    = 1'b0;
    c_wdata = '0;
    f_addr  = FONT_AW'(in_faddr);
    f_we    = 1'b0;
    f_re    = 1'b0;

    if (oval_q && m_axis_tready_i) begin
      oval_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        c_we  = 1'b1;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == CELL_DEPTH - 1) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_acc) begin
          case (in_kind)
            KIND_CELL: begin
              c_addr  = CELL_AW'(32'(in_row) * MAP_COLUMNS + 32'(in_col));
              c_wdata = in_code;
              c_we    = (in_col < used_cols) && (in_row < used_rows);
            end
            KIND_CLEAR: state_d = ST_CLEAR;
            KIND_FONT:  f_we = 1'b1;
            KIND_QUERY: begin
              if (early) begin
                res_d   = '1;
                state_d = ST_RES;
              end else begin
                state_d = ST_DIV;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if ((div_rsp.quo_x >= DIV_W'(used_cols)) ||
              (div_rsp.quo_y >= DIV_W'(used_rows))) begin
            res_d   = '1;
            state_d = ST_RES;
          end else begin
            c_addr  = CELL_AW'(32'(div_rsp.quo_y[4:0]) * MAP_COLUMNS
                               + 32'(div_rsp.quo_x[5:0]));
            c_re    = 1'b1;
            off_d   = 14'(div_rsp.rem_y * gw_q) + 14'(div_rsp.rem_x);
            state_d = ST_CODE;
          end
        end
      end
      ST_CODE: begin
        if (c_rdata == '0) begin
          res_d   = '1;
          state_d = ST_RES;
        end else begin
          f_addr  = FONT_AW'(32'({c_rdata[8] & page2_q, c_rdata[7:0]}) * GLYPH_PIXELS
                             + 32'(off_q));
          f_re    = 1'b1;
          state_d = ST_FONT;
        end
      end
      ST_FONT: begin
        res_d   = {~f_rdata[31:24], f_rdata[7:0], f_rdata[15:8], f_rdata[23:16]};
        state_d = ST_RES;
      end
      ST_RES: begin
        if (!oval_q || m_axis_tready_i) begin
          out_d   = res_q;
          oval_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      oval_q  <= 1'b0;
      cols_q  <= 6'd31;
      rows_q  <= 5'd15;
      gw_q    <= 7'd36;
      gh_q    <= 7'd54;
      ox_q    <= 11'd180;
      oy_q    <= 10'd0;
      page2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      oval_q  <= oval_d;
      if (cfg_valid_i) begin
        case (reg_e'(cfg_index_i))
          REG_CHAR_COLUMNS: cols_q  <= cfg_data_i[5:0];
          REG_CHAR_ROWS:    rows_q  <= cfg_data_i[4:0];
          REG_GLYPH_WIDTH:  gw_q    <= cfg_data_i[6:0];
          REG_GLYPH_HEIGHT: gh_q    <= cfg_data_i[6:0];
          REG_ORIGIN_X:     ox_q    <= cfg_data_i[10:0];
          REG_ORIGIN_Y:     oy_q    <= cfg_data_i[9:0];
          REG_SECOND_PAGE:  page2_q <= cfg_data_i[0];
          default:          page2_q <= page2_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    off_q <= off_d;
    out_q <= out_d;
  end

endmodule

// ----- tb/sv/osd_character_overlay_renderer_core_tb.sv -----
`timescale 1ns / 1ps

module osd_character_overlay_renderer_core_tb;
  import osd_pkg::*;

  class pixel_scoreboard;
    logic [5:0]  cols;
    logic [4:0]  rows;
    logic [6:0]  gw;
    logic [6:0]  gh;
    logic [10:0] ox;
    logic [9:0]  oy;
    logic        page2;
    logic [8:0]  codes[CELL_DEPTH];
    logic [31:0] font[int];
    logic [31:0] pixel_q[$];
    int          mismatches;

    function new();
      cols = 31; rows = 15; gw = 36; gh = 54; ox = 180; oy = 0; page2 = 0;
      foreach (codes[i]) codes[i] = '0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_e idx, logic [10:0] v);
      case (idx)
        REG_CHAR_COLUMNS: cols = v[5:0];
        REG_CHAR_ROWS:    rows = v[4:0];
        REG_GLYPH_WIDTH:  gw = v[6:0];
        REG_GLYPH_HEIGHT: gh = v[6:0];
        REG_ORIGIN_X:     ox = v;
        REG_ORIGIN_Y:     oy = v[9:0];
        REG_SECOND_PAGE:  page2 = v[0];
        default: ;
      endcase
    endfunction

    function int used_cols();
      return (cols < MAP_COLUMNS) ? int'(cols) : MAP_COLUMNS;
    endfunction

    function int used_rows();
      return (rows < MAP_ROWS) ? int'(rows) : MAP_ROWS;
    endfunction

    // Return 1 when the pixel is drawn from a glyph, with the font word index.
    function bit glyph_lookup(int px, int py, output int addr);
      int dx, dy, col, row, code, page;
      addr = 0;
      if (px >= FRAME_WIDTH || py >= FRAME_HEIGHT) return 0;
      if (gw == 0 || gh == 0) return 0;
      if (px < ox || py < oy) return 0;
      dx = px - ox;
      dy = py - oy;
      col = dx / gw;
      row = dy / gh;
      if (col >= used_cols() || row >= used_rows()) return 0;
      code = codes[row * MAP_COLUMNS + col];
      if (code == 0) return 0;
      page = (code > 255 && page2) ? 1 : 0;
      addr = (page * GLYPHS_PER_PAGE + (code & 255)) * GLYPH_PIXELS
             + (dy % gh) * gw + (dx % gw);
      addr = addr % FONT_DEPTH;
      return 1;
    endfunction

    function void note_item(kind_e k, logic [95:0] d);
      int addr;
      logic [31:0] w;
      case (k)
        KIND_CELL: begin
          if (d[5:0] < used_cols() && d[10:6] < used_rows())
            codes[d[10:6] * MAP_COLUMNS + d[5:0]] = d[19:11];
        end
        KIND_CLEAR: foreach (codes[i]) codes[i] = '0;
        KIND_FONT: begin
          if (d[40:20] < FONT_DEPTH) font[int'(d[40:20])] = d[72:41];
        end
        default: begin
          if (glyph_lookup(int'(d[83:73]), int'(d[93:84]), addr)) begin
            w = font.exists(addr) ? font[addr] : 32'h0;
            pixel_q.push_back({~w[31:24], w[7:0], w[15:8], w[23:16]});
          end else begin
            pixel_q.push_back(32'hFFFF_FFFF);
          end
        end
      endcase
    endfunction

    function void check_pixel(logic [31:0] act);
      logic [31:0] exp_px;
      bit bad;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel transaction %h", act);
        return;
      end
      exp_px = pixel_q.pop_front();
      bad = 0;
      for (int b = 0; b < 4; b++)
        if (act[8*b +: 8] !== exp_px[8*b +: 8]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel mismatch: expected %h actual %h", exp_px, act);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [10:0] cfg_data_i;

  pixel_scoreboard sb;
  int burst_left;
  int stall_mode;
  int stall_len;

  osd_character_overlay_renderer_core DUT (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_pixel(m_axis_tdata_o);

  // vary the receiver's stall pattern in stretches
  always @(negedge clk_i) begin
    if (stall_len == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_len = $urandom_range(32, 256);
    end
    stall_len--;
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready_i <= (stall_len % 20) < 3;
    endcase
  end

  task automatic send_item(kind_e k, logic [95:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = k;
    s_axis_tdata_i = d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(k, d);
  endtask

  function automatic logic [95:0] noise();
    return {$urandom(), $urandom(), $urandom()} & 96'h3FFF_FFFF_FFFF_FFFF_FFFF_FFFF;
  endfunction

  task automatic write_cell(int col, int row, int code);
    logic [95:0] d;
    d = noise();
    d[5:0] = 6'(col); d[10:6] = 5'(row); d[19:11] = 9'(code);
    send_item(KIND_CELL, d);
  endtask

  task automatic write_font(int addr, logic [31:0] w);
    logic [95:0] d;
    d = noise();
    d[40:20] = 21'(addr); d[72:41] = w;
    send_item(KIND_FONT, d);
  endtask

  // load the font word first if the query would read a word never written
  task automatic query(int px, int py);
    logic [95:0] d;
    int addr;
    if (sb.glyph_lookup(px, py, addr) && !sb.font.exists(addr))
      write_font(addr, $urandom());
    d = noise();
    d[83:73] = 11'(px); d[93:84] = 10'(py);
    send_item(KIND_QUERY, d);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = 11'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, 11'(v));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(int c, int r, int w, int h, int x, int y, int p);
    wait_idle();
    write_reg(REG_CHAR_COLUMNS, c);
    write_reg(REG_CHAR_ROWS, r);
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_ORIGIN_X, x);
    write_reg(REG_ORIGIN_Y, y);
    write_reg(REG_SECOND_PAGE, p);
  endtask

  task automatic random_item();
    int sel, col, row, px, py;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      if ($urandom_range(0, 4) != 0 && sb.used_cols() > 0 && sb.used_rows() > 0)
        write_cell($urandom_range(0, sb.used_cols() - 1), $urandom_range(0, sb.used_rows() - 1),
                   $urandom_range(1, 511));
      else
        write_cell($urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 511));
    end else if (sel < 27) begin
      send_item(KIND_CLEAR, noise());
    end else if (sel < 37) begin
      write_font($urandom_range(0, 2097151), $urandom());
    end else begin
      px = 4096;
      py = 4096;
      if ($urandom_range(0, 4) != 0 && sb.gw > 0 && sb.gh > 0 &&
          sb.used_cols() > 0 && sb.used_rows() > 0) begin
        col = $urandom_range(0, sb.used_cols() - 1);
        row = $urandom_range(0, sb.used_rows() - 1);
        px = sb.ox + col * sb.gw + $urandom_range(0, sb.gw - 1);
        py = sb.oy + row * sb.gh + $urandom_range(0, sb.gh - 1);
      end
      if (px > 2047 || py > 1023) begin
        px = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 1439);
        py = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 809);
      end
      query(px, py);
    end
  endtask

  task automatic random_run(int n);
    repeat (n) random_item();
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    stall_len = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = KIND_CELL;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_CHAR_COLUMNS;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_cell(0, 0, 1);
    write_cell(30, 14, 511);
    write_cell(1, 0, 256);
    write_cell(63, 31, 5);
    write_cell(31, 0, 7);
    write_font(2097151, 32'hFFFF_FFFF);
    write_font(0, 32'h0);
    query(180, 0);
    query(180 + 35, 53);
    query(180 + 30 * 36 + 5, 14 * 54 + 9);
    query(180 + 36 + 2, 3);
    query(180 + 72, 0);
    query(179, 10);
    query(180 + 31 * 36, 0);
    query(2047, 1023);
    query(1440, 0);
    query(0, 810);
    send_item(KIND_CLEAR, noise());
    query(180, 0);
    random_run(100);

    configure(50, 18, 64, 64, 0, 0, 1);
    write_cell(49, 17, 300);
    write_cell(0, 0, 511);
    query(0, 0);
    query(1439, 809);
    random_run(120);
    configure(1, 1, 1, 1, 1439, 809, 0);
    write_cell(0, 0, 300);
    query(1439, 809);
    random_run(80);
    configure(63, 31, 7, 5, 100, 37, 1);
    random_run(120);
    configure(0, 4, 0, 9, 0, 0, 1);
    random_run(40);
    configure(20, 0, 9, 127, 2047, 1023, 0);
    random_run(40);
    configure(40, 12, 127, 0, 5, 5, 1);
    random_run(40);
    configure($urandom_range(1, 50), $urandom_range(1, 18), $urandom_range(1, 64),
              $urandom_range(1, 64), $urandom_range(0, 600), $urandom_range(0, 300), 1);
    random_run(140);
    configure(31, 15, 36, 54, 180, 0, 0);
    random_run(120);

    wait_idle();
    if (sb.mismatches == 0 && sb.pixel_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
